>>> sv/rational_arithmetic_unit_defines.svh
// assertion macros shared by the rational arithmetic unit files
`ifndef RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH
`define RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define RAU_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define RAU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/rau_pkg.sv
// types and constants of the rational arithmetic unit
package rau_pkg;

   localparam int FIELD_BITS = 32;
   localparam int DEN_BITS   = 31;

   localparam logic [2:0] OP_NORM = 3'd0;
   localparam logic [2:0] OP_ADD  = 3'd1;
   localparam logic [2:0] OP_SUB  = 3'd2;
   localparam logic [2:0] OP_MUL  = 3'd3;
   localparam logic [2:0] OP_DIV  = 3'd4;
   localparam logic [2:0] OP_CMP  = 3'd5;

   // which cross product the multiplier is working on
   localparam logic [1:0] PROD_P1 = 2'd0;
   localparam logic [1:0] PROD_P2 = 2'd1;
   localparam logic [1:0] PROD_P3 = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_START,
      ST_MUL,
      ST_COMBINE,
      ST_CMP,
      ST_NORM,
      ST_TWOS,
      ST_GCD,
      ST_DIV_N,
      ST_DIV_D,
      ST_SIGN,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      MODE_MUL,
      MODE_DIV,
      MODE_GCD
   } unit_mode_type;

   typedef struct packed {
      logic          start;
      unit_mode_type mode;
   } unit_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_stat_type;

   typedef struct packed {
      logic [2:0]                   op;
      logic signed [FIELD_BITS-1:0] a_num;
      logic signed [FIELD_BITS-1:0] a_den;
      logic signed [FIELD_BITS-1:0] b_num;
      logic signed [FIELD_BITS-1:0] b_den;
   } req_type;

   typedef struct packed {
      logic signed [FIELD_BITS-1:0] res_num;
      logic [DEN_BITS-1:0]          res_den;
      logic                         less;
      logic                         greater;
      logic                         equal;
      logic                         zero_den;
      logic                         overflow;
   } rsp_type;

endpackage

>>> sv/rau_stream_if.sv
// valid/ready channel carrying one transaction payload
interface rau_stream_if #(parameter type payload_type = logic);

   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);

endinterface

>>> sv/rau_shared_unit.sv
// bit-serial multiplier, restoring divider and binary gcd on one shared adder
`include "rational_arithmetic_unit_defines.svh"

module rau_shared_unit #(
   parameter int WORD_BITS = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  rau_pkg::unit_ctrl_type unit_ctrl,
   output rau_pkg::unit_stat_type unit_stat,
   input  logic [WORD_BITS-1:0]   opa,
   input  logic [WORD_BITS-1:0]   opb,
   output logic [WORD_BITS-1:0]   res_hi,
   output logic [WORD_BITS-1:0]   res_lo
);
   import rau_pkg::*;

   localparam int W        = WORD_BITS;
   localparam int CNT_BITS = $clog2(WORD_BITS);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   unit_mode_type       mode_ff, mode_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [W-1:0]        hi_ff, hi_in;
   logic [W-1:0]        lo_ff, lo_in;
   logic [W-1:0]        aux_ff, aux_in;

   logic [W:0]   add_a;
   logic [W:0]   add_b;
   logic         add_sub;
   logic [W+1:0] add_res;
   logic         last_step;
   logic         u_zero;
   logic         v_zero;

   // the one shared adder
   always_comb begin
      add_sub = 1'b0;
      add_a   = {1'b0, hi_ff};
      add_b   = '0;
      case (mode_ff)
         MODE_MUL: begin
            add_a = {1'b0, hi_ff};
            add_b = lo_ff[0] ? {1'b0, aux_ff} : '0;
         end
         MODE_DIV: begin
            add_a   = {hi_ff, lo_ff[W-1]};
            add_b   = {1'b0, aux_ff};
            add_sub = 1'b1;
         end
         default: begin
            add_a   = {1'b0, hi_ff};
            add_b   = {1'b0, lo_ff};
            add_sub = 1'b1;
         end
      endcase
   end

   assign add_res   = add_sub ? ({1'b0, add_a} - {1'b0, add_b})
                              : ({1'b0, add_a} + {1'b0, add_b});
   assign last_step = (cnt_ff == CNT_BITS'(W - 1));
   assign u_zero    = (hi_ff == '0);
   assign v_zero    = (lo_ff == '0);

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      mode_in = mode_ff;
      cnt_in  = cnt_ff;
      hi_in   = hi_ff;
      lo_in   = lo_ff;
      aux_in  = aux_ff;
      if (!busy_ff) begin
         if (unit_ctrl.start) begin
            busy_in = 1'b1;
            mode_in = unit_ctrl.mode;
            cnt_in  = '0;
            case (unit_ctrl.mode)
               MODE_MUL: begin
                  hi_in  = '0;
                  lo_in  = opb;
                  aux_in = opa;
               end
               MODE_DIV: begin
                  hi_in  = '0;
                  lo_in  = opa;
                  aux_in = opb;
               end
               default: begin
                  hi_in = opa;
                  lo_in = opb;
               end
            endcase
         end
      end else begin
         cnt_in = cnt_ff + 1'b1;
         case (mode_ff)
            MODE_MUL: begin
               {hi_in, lo_in} = {add_res[W:0], lo_ff[W-1:1]};
               if (last_step) begin
                  busy_in = 1'b0;
                  done_in = 1'b1;
               end
            end
            MODE_DIV: begin
               hi_in = add_res[W+1] ? add_a[W-1:0] : add_res[W-1:0];
               lo_in = {lo_ff[W-2:0], ~add_res[W+1]};
               if (last_step) begin
                  busy_in = 1'b0;
                  done_in = 1'b1;
               end
            end
            default: begin
               if (u_zero) begin
                  busy_in = 1'b0;
                  done_in = 1'b1;
               end else if (v_zero) begin
                  lo_in   = hi_ff;
                  busy_in = 1'b0;
                  done_in = 1'b1;
               end else if (!hi_ff[0]) begin
                  hi_in = hi_ff >> 1;
               end else if (!lo_ff[0]) begin
                  lo_in = lo_ff >> 1;
               end else if (add_res[W+1]) begin
                  hi_in = lo_ff;
                  lo_in = hi_ff;
               end else begin
                  hi_in = add_res[W-1:0];
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         mode_ff <= MODE_MUL;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         mode_ff <= mode_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      hi_ff  <= hi_in;
      lo_ff  <= lo_in;
      aux_ff <= aux_in;
   end

   assign unit_stat.busy = busy_ff;
   assign unit_stat.done = done_ff;
   assign res_hi         = hi_ff;
   assign res_lo         = lo_ff;

   `RAU_ASSERT_NEXT(a_done_pulse, clock, reset, done_ff, !done_ff, "unit done held")
   `RAU_ASSERT_IMPL(a_start_idle, clock, reset, unit_ctrl.start, !busy_ff && !done_ff, "unit restarted while active")
   `RAU_ASSERT_IMPL(a_gcd_live, clock, reset, busy_ff && mode_ff == MODE_GCD, !(u_zero && v_zero), "gcd operands both zero")

endmodule

>>> sv/rational_arithmetic_unit.sv
// top level of the rational arithmetic unit: sequencer around the shared unit
//
//  channel | direction | payload  | transaction when
//  --------+-----------+----------+-------------------------
//  req_bus | in        | req_type | req_bus.valid & ready
//  rsp_bus | out       | rsp_type | rsp_bus.valid & ready
//
// one transaction at a time; req_bus.ready is high only while the sequencer is idle
// a multiply or a divide holds the shared unit until the unit raises done
// binary gcd runs until one of its operands reaches zero
// unused op codes skip the shared unit and give 0/1; a compare takes two cross products
// the result register frees the sequencer, so a new request is taken while it waits
// synchronous reset returns to idle with no result pending
`include "rational_arithmetic_unit_defines.svh"

module rational_arithmetic_unit #(
   parameter int WORD_BITS = 32
) (
   input logic          clock,
   input logic          reset,
   rau_stream_if.sink   req_bus,
   rau_stream_if.source rsp_bus
);
   import rau_pkg::*;

   localparam int W = WORD_BITS;
   localparam logic [W-1:0] MIN_MAG = {1'b1, {(W-1){1'b0}}};
   localparam logic [W-2:0] RD_ONE  = (W-1)'(1);
   localparam logic [W-2:0] RD_SAT  = '1;

   state_type    state_ff, state_in;
   logic [2:0]   op_ff, op_in;
   logic [W-1:0] an_ff, an_in, ad_ff, ad_in, bn_ff, bn_in, bd_ff, bd_in;
   logic [W-1:0] x_ff, x_in, y_ff, y_in, g_ff, g_in;
   logic [1:0]   idx_ff, idx_in;
   logic         sgn_ff, sgn_in;
   logic [W-1:0] rn_ff, rn_in;
   logic [W-2:0] rd_ff, rd_in;
   logic         lt_ff, lt_in, gt_ff, gt_in, eq_ff, eq_in;
   logic         zd_ff, zd_in, ovf_ff, ovf_in;
   rsp_type      out_ff, out_in;
   logic         out_vld_ff, out_vld_in;

   unit_ctrl_type unit_ctrl;
   unit_stat_type unit_stat;
   logic [W-1:0]  unit_opa, unit_opb, unit_hi, unit_lo;

   logic         accept, out_free, den_eq, unit_wait;
   logic [W-1:0] mul_sa, mul_sb, mag_a, mag_b, prod_wrap;
   logic         prod_neg, prod_ovf;
   logic [W-1:0] cmb_sum, x_mag, y_mag;
   logic         cmb_ovf, is_addsub;

   rau_shared_unit #(
      .WORD_BITS(WORD_BITS)
   ) u_shared (
      .clock    (clock),
      .reset    (reset),
      .unit_ctrl(unit_ctrl),
      .unit_stat(unit_stat),
      .opa      (unit_opa),
      .opb      (unit_opb),
      .res_hi   (unit_hi),
      .res_lo   (unit_lo)
   );

   assign accept    = req_bus.valid && req_bus.ready;
   assign out_free  = !out_vld_ff || rsp_bus.ready;
   assign den_eq    = (ad_ff == bd_ff);
   assign is_addsub = (op_ff == OP_ADD) || (op_ff == OP_SUB);

   // cross product operand selection
   always_comb begin
      mul_sa = ad_ff;
      mul_sb = bd_ff;
      case (idx_ff)
         PROD_P1: begin
            mul_sa = an_ff;
            mul_sb = (op_ff == OP_MUL) ? bn_ff : bd_ff;
         end
         PROD_P2: begin
            if (op_ff == OP_MUL) begin
               mul_sa = ad_ff;
               mul_sb = bd_ff;
            end else if (is_addsub) begin
               mul_sa = bn_ff;
               mul_sb = ad_ff;
            end else begin
               mul_sa = ad_ff;
               mul_sb = bn_ff;
            end
         end
         default: begin
            mul_sa = ad_ff;
            mul_sb = bd_ff;
         end
      endcase
   end

   assign mag_a     = mul_sa[W-1] ? -mul_sa : mul_sa;
   assign mag_b     = mul_sb[W-1] ? -mul_sb : mul_sb;
   assign prod_neg  = mul_sa[W-1] ^ mul_sb[W-1];
   assign prod_wrap = prod_neg ? -unit_lo : unit_lo;
   assign prod_ovf  = ({unit_hi, unit_lo[W-1]} != '0)
                      && !(prod_neg && unit_hi == '0 && unit_lo == MIN_MAG);

   assign cmb_sum = (op_ff == OP_SUB) ? (x_ff - y_ff) : (x_ff + y_ff);
   assign cmb_ovf = (op_ff == OP_SUB)
                    ? ((x_ff[W-1] != y_ff[W-1]) && (cmb_sum[W-1] != x_ff[W-1]))
                    : ((x_ff[W-1] == y_ff[W-1]) && (cmb_sum[W-1] != x_ff[W-1]));

   assign x_mag = x_ff[W-1] ? -x_ff : x_ff;
   assign y_mag = y_ff[W-1] ? -y_ff : y_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               state_in = ST_START;
            end
         end
         ST_START: begin
            unique case (op_ff) inside
               OP_NORM:                 state_in = ST_NORM;
               OP_ADD, OP_SUB:          state_in = den_eq ? ST_COMBINE : ST_MUL;
               OP_MUL, OP_DIV, OP_CMP:  state_in = ST_MUL;
               default:                 state_in = ST_FINISH;
            endcase
         end
         ST_MUL: begin
            if (unit_stat.done) begin
               if (idx_ff == PROD_P1) begin
                  state_in = ST_MUL;
               end else if (idx_ff == PROD_P2 && op_ff == OP_CMP) begin
                  state_in = ST_CMP;
               end else if (idx_ff == PROD_P2 && is_addsub) begin
                  state_in = ST_COMBINE;
               end else begin
                  state_in = ST_NORM;
               end
            end
         end
         ST_COMBINE: state_in = den_eq ? ST_NORM : ST_MUL;
         ST_CMP:     state_in = ST_FINISH;
         ST_NORM: begin
            state_in = (x_ff == '0 || y_ff == '0) ? ST_FINISH : ST_TWOS;
         end
         ST_TWOS: begin
            if (x_ff[0] || y_ff[0]) begin
               state_in = ST_GCD;
            end
         end
         ST_GCD: begin
            if (unit_stat.done) begin
               state_in = ST_DIV_N;
            end
         end
         ST_DIV_N: begin
            if (unit_stat.done) begin
               state_in = ST_DIV_D;
            end
         end
         ST_DIV_D: begin
            if (unit_stat.done) begin
               state_in = ST_SIGN;
            end
         end
         ST_SIGN: state_in = ST_FINISH;
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs to the channel and the shared unit
   always_comb begin
      req_bus.ready  = (state_ff == ST_IDLE);
      unit_wait      = 1'b0;
      unit_ctrl.mode = MODE_MUL;
      unit_opa       = mag_a;
      unit_opb       = mag_b;
      unique case (state_ff)
         ST_MUL: begin
            unit_wait      = 1'b1;
            unit_ctrl.mode = MODE_MUL;
            unit_opa       = mag_a;
            unit_opb       = mag_b;
         end
         ST_GCD: begin
            unit_wait      = 1'b1;
            unit_ctrl.mode = MODE_GCD;
            unit_opa       = x_ff;
            unit_opb       = y_ff;
         end
         ST_DIV_N: begin
            unit_wait      = 1'b1;
            unit_ctrl.mode = MODE_DIV;
            unit_opa       = x_ff;
            unit_opb       = g_ff;
         end
         ST_DIV_D: begin
            unit_wait      = 1'b1;
            unit_ctrl.mode = MODE_DIV;
            unit_opa       = y_ff;
            unit_opb       = g_ff;
         end
         default: begin
            unit_wait = 1'b0;
         end
      endcase
      unit_ctrl.start = unit_wait && !unit_stat.busy && !unit_stat.done;
   end

   // datapath
   always_comb begin
      op_in      = op_ff;
      an_in      = an_ff;
      ad_in      = ad_ff;
      bn_in      = bn_ff;
      bd_in      = bd_ff;
      x_in       = x_ff;
      y_in       = y_ff;
      g_in       = g_ff;
      idx_in     = idx_ff;
      sgn_in     = sgn_ff;
      rn_in      = rn_ff;
      rd_in      = rd_ff;
      lt_in      = lt_ff;
      gt_in      = gt_ff;
      eq_in      = eq_ff;
      zd_in      = zd_ff;
      ovf_in     = ovf_ff;
      out_in     = out_ff;
      out_vld_in = out_vld_ff;

      if (out_vld_ff && rsp_bus.ready) begin
         out_vld_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in  = req_bus.data.op;
               an_in  = W'(signed'(req_bus.data.a_num));
               ad_in  = W'(signed'(req_bus.data.a_den));
               bn_in  = W'(signed'(req_bus.data.b_num));
               bd_in  = W'(signed'(req_bus.data.b_den));
               idx_in = PROD_P1;
               lt_in  = 1'b0;
               gt_in  = 1'b0;
               eq_in  = 1'b0;
               zd_in  = 1'b0;
               ovf_in = 1'b0;
            end
         end
         ST_START: begin
            if (op_ff == OP_NORM) begin
               x_in = an_ff;
               y_in = ad_ff;
            end else if (is_addsub) begin
               x_in = an_ff;
               y_in = bn_ff;
            end else if (op_ff != OP_MUL && op_ff != OP_DIV && op_ff != OP_CMP) begin
               rn_in = '0;
               rd_in = RD_ONE;
            end
         end
         ST_MUL: begin
            if (unit_stat.done) begin
               ovf_in = ovf_ff | prod_ovf;
               if (idx_ff == PROD_P1) begin
                  x_in   = prod_wrap;
                  idx_in = PROD_P2;
               end else begin
                  y_in = prod_wrap;
               end
            end
         end
         ST_COMBINE: begin
            x_in   = cmb_sum;
            ovf_in = ovf_ff | cmb_ovf;
            if (den_eq) begin
               y_in = ad_ff;
            end else begin
               idx_in = PROD_P3;
            end
         end
         ST_CMP: begin
            lt_in = $signed(x_ff) < $signed(y_ff);
            gt_in = $signed(y_ff) < $signed(x_ff);
            eq_in = (an_ff == bn_ff) && (ad_ff == bd_ff);
            rn_in = '0;
            rd_in = RD_ONE;
         end
         ST_NORM: begin
            if (y_ff == '0) begin
               rn_in = x_ff;
               rd_in = RD_ONE;
               zd_in = 1'b1;
            end else if (x_ff == '0) begin
               rn_in = '0;
               rd_in = RD_ONE;
            end else begin
               sgn_in = x_ff[W-1] ^ y_ff[W-1];
               x_in   = x_mag;
               y_in   = y_mag;
            end
         end
         ST_TWOS: begin
            if (!x_ff[0] && !y_ff[0]) begin
               x_in = x_ff >> 1;
               y_in = y_ff >> 1;
            end
         end
         ST_GCD: begin
            if (unit_stat.done) begin
               g_in = unit_lo;
            end
         end
         ST_DIV_N: begin
            if (unit_stat.done) begin
               x_in = unit_lo;
            end
         end
         ST_DIV_D: begin
            if (unit_stat.done) begin
               y_in = unit_lo;
            end
         end
         ST_SIGN: begin
            if (y_ff[W-1]) begin
               rd_in  = RD_SAT;
               ovf_in = 1'b1;
            end else begin
               rd_in = y_ff[W-2:0];
            end
            if (!sgn_ff && x_ff[W-1]) begin
               ovf_in = 1'b1;
            end
            rn_in = sgn_ff ? -x_ff : x_ff;
         end
         ST_FINISH: begin
            if (out_free) begin
               out_in.res_num  = FIELD_BITS'(signed'(rn_ff));
               out_in.res_den  = DEN_BITS'(rd_ff);
               out_in.less     = lt_ff;
               out_in.greater  = gt_ff;
               out_in.equal    = eq_ff;
               out_in.zero_den = zd_ff;
               out_in.overflow = ovf_ff;
               out_vld_in      = 1'b1;
            end
         end
         default: begin
            out_vld_in = out_vld_in;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      an_ff  <= an_in;
      ad_ff  <= ad_in;
      bn_ff  <= bn_in;
      bd_ff  <= bd_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      g_ff   <= g_in;
      idx_ff <= idx_in;
      sgn_ff <= sgn_in;
      rn_ff  <= rn_in;
      rd_ff  <= rd_in;
      lt_ff  <= lt_in;
      gt_ff  <= gt_in;
      eq_ff  <= eq_in;
      zd_ff  <= zd_in;
      ovf_ff <= ovf_in;
      out_ff <= out_in;
   end

   assign rsp_bus.valid = out_vld_ff;
   assign rsp_bus.data  = out_ff;

   `RAU_ASSERT_IMPL(a_den_nonzero, clock, reset, state_ff == ST_FINISH, rd_ff != '0, "result denominator is zero")
   `RAU_ASSERT_IMPL(a_cmp_flags, clock, reset, state_ff == ST_FINISH, $onehot0({lt_ff, gt_ff, eq_ff, zd_ff}), "conflicting result flags")
   `RAU_ASSERT_IMPL(a_gcd_operands, clock, reset, state_ff == ST_GCD, x_ff != '0 && y_ff != '0 && (x_ff[0] || y_ff[0]), "bad gcd operands")

endmodule

>>> test/tb_top.sv
// self-checking testbench of the rational arithmetic unit with random traffic and stalls
module tb_top;
   import rau_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int          CLOCK_PERIOD   = 10;
   localparam int          RESET_CYCLES   = 12;
   localparam int          RANDOM_ITEMS   = 1225;
   localparam int          DRAIN_CYCLES   = 40;
   localparam int          WATCHDOG_LIMIT = 4000;
   localparam int          REPORT_LIMIT   = 10;
   localparam logic [2:0]  OP_SPARE_6     = 3'd6;
   localparam logic [2:0]  OP_SPARE_7     = 3'd7;
   localparam logic [31:0] WORD_MAX       = 32'h7FFF_FFFF;
   localparam logic [31:0] WORD_MIN       = 32'h8000_0000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rau_stream_if #(.payload_type(req_type)) req_if ();
   rau_stream_if #(.payload_type(rsp_type)) rsp_if ();

   rational_arithmetic_unit #(.WORD_BITS(FIELD_BITS)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if)
   );

   req_type     pending_requests[$];
   rsp_type     expected_results[$];
   int unsigned total_requests    = 0;
   int unsigned accepted_requests = 0;
   int unsigned received_results  = 0;
   int unsigned mismatch_count    = 0;
   int unsigned gap_left          = 0;
   int unsigned hold_off          = 0;
   int unsigned idle_cycles       = 0;
   logic        arith_wrap;

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // fraction arithmetic at 32 bits
   function automatic logic [31:0] magnitude(logic [31:0] v);
      return v[31] ? -v : v;
   endfunction

   function automatic logic [31:0] add_wrap(logic [31:0] a, logic [31:0] b);
      logic [31:0] s;
      s = a + b;
      if (a[31] == b[31] && s[31] != a[31])
         arith_wrap = 1'b1;
      return s;
   endfunction

   function automatic logic [31:0] sub_wrap(logic [31:0] a, logic [31:0] b);
      logic [31:0] s;
      s = a - b;
      if (a[31] != b[31] && s[31] != a[31])
         arith_wrap = 1'b1;
      return s;
   endfunction

   function automatic logic [31:0] mul_wrap(logic [31:0] a, logic [31:0] b);
      logic [63:0] prod;
      logic [63:0] limit;
      prod  = {32'd0, magnitude(a)} * {32'd0, magnitude(b)};
      limit = (a[31] != b[31] && prod != 64'd0) ? 64'h8000_0000 : 64'h7FFF_FFFF;
      if (prod > limit)
         arith_wrap = 1'b1;
      return a * b;
   endfunction

   function automatic logic [31:0] euclid_gcd(logic [31:0] x, logic [31:0] y);
      logic [31:0] t;
      while (y != 32'd0) begin
         t = x % y;
         x = y;
         y = t;
      end
      return x;
   endfunction

   function automatic void reduce_fraction(input logic [31:0] n, input logic [31:0] d,
                                           output logic [31:0] rn, output logic [30:0] rd,
                                           output logic zd);
      logic [31:0] mn, md, g;
      logic        s;
      rn = n;
      rd = 31'd1;
      zd = 1'b0;
      if (d == 32'd0) begin
         zd = 1'b1;
         return;
      end
      if (n == 32'd0) begin
         rn = 32'd0;
         return;
      end
      s  = n[31] ^ d[31];
      mn = magnitude(n);
      md = magnitude(d);
      g  = euclid_gcd(mn, md);
      mn = mn / g;
      md = md / g;
      if (md > WORD_MAX) begin
         arith_wrap = 1'b1;
         md = WORD_MAX;
      end
      if (!s && mn > WORD_MAX)
         arith_wrap = 1'b1;
      rn = s ? -mn : mn;
      rd = md[30:0];
   endfunction

   function automatic rsp_type rational_result(req_type r);
      rsp_type     e;
      logic [31:0] an, ad, bn, bd, x, y;
      e = '0;
      e.res_den = 31'd1;
      arith_wrap = 1'b0;
      an = r.a_num;
      ad = r.a_den;
      bn = r.b_num;
      bd = r.b_den;
      case (r.op)
         OP_NORM: begin
            reduce_fraction(an, ad, e.res_num, e.res_den, e.zero_den);
         end
         OP_ADD, OP_SUB: begin
            if (ad == bd) begin
               x = (r.op == OP_ADD) ? add_wrap(an, bn) : sub_wrap(an, bn);
               y = ad;
            end else begin
               x = (r.op == OP_ADD) ? add_wrap(mul_wrap(an, bd), mul_wrap(bn, ad))
                                    : sub_wrap(mul_wrap(an, bd), mul_wrap(bn, ad));
               y = mul_wrap(ad, bd);
            end
            reduce_fraction(x, y, e.res_num, e.res_den, e.zero_den);
         end
         OP_MUL: begin
            x = mul_wrap(an, bn);
            y = mul_wrap(ad, bd);
            reduce_fraction(x, y, e.res_num, e.res_den, e.zero_den);
         end
         OP_DIV: begin
            x = mul_wrap(an, bd);
            y = mul_wrap(ad, bn);
            reduce_fraction(x, y, e.res_num, e.res_den, e.zero_den);
         end
         OP_CMP: begin
            x = mul_wrap(an, bd);
            y = mul_wrap(ad, bn);
            e.less    = $signed(x) < $signed(y);
            e.greater = $signed(y) < $signed(x);
            e.equal   = (an == bn) && (ad == bd);
         end
         default: begin
         end
      endcase
      e.overflow = arith_wrap;
      return e;
   endfunction

   // stimulus
   function automatic void add_request(logic [2:0] op, logic [31:0] an, logic [31:0] ad,
                                       logic [31:0] bn, logic [31:0] bd);
      req_type r;
      r.op    = op;
      r.a_num = an;
      r.a_den = ad;
      r.b_num = bn;
      r.b_den = bd;
      pending_requests.push_back(r);
   endfunction

   function automatic logic [31:0] pick_word();
      logic [31:0] corners[8];
      corners = '{32'd0, 32'd1, 32'hFFFF_FFFF, WORD_MAX, WORD_MIN, 32'd2,
                  32'h4000_0000, 32'h8000_0001};
      case ($urandom_range(0, 5))
         0: return corners[$urandom_range(0, 7)];
         1: return $urandom_range(0, 40) - 20;
         2: return $urandom_range(0, 100000) - 50000;
         default: return $urandom;
      endcase
   endfunction

   function automatic void make_fraction(output logic [31:0] n, output logic [31:0] d);
      logic [31:0] g, m;
      case ($urandom_range(0, 3))
         0: begin
            n = $urandom_range(0, 40) - 20;
            d = $urandom_range(1, 12);
         end
         1: begin
            n = $urandom_range(0, 20000) - 10000;
            d = $urandom_range(1, 1000);
         end
         2: begin
            n = $urandom;
            d = $urandom_range(1, WORD_MAX);
         end
         default: begin
            n = $urandom_range(0, 200) - 100;
            d = 32'd1;
         end
      endcase
      if (n == 32'd0) begin
         d = 32'd1;
      end else begin
         m = magnitude(n);
         g = euclid_gcd(m, d);
         m = m / g;
         d = d / g;
         n = n[31] ? -m : m;
      end
   endfunction

   function automatic void add_random_request();
      logic [2:0]  op;
      logic [31:0] an, ad, bn, bd, k;
      op = ($urandom_range(0, 49) == 0) ? 3'($urandom_range(OP_SPARE_6, OP_SPARE_7))
                                        : 3'($urandom_range(OP_NORM, OP_CMP));
      if ($urandom_range(0, 9) < 8) begin
         make_fraction(an, ad);
         make_fraction(bn, bd);
         if (op == OP_NORM) begin
            k  = $urandom_range(1, 30);
            an = an * k;
            ad = ad * k;
            if ($urandom_range(0, 1) == 0)
               ad = -ad;
            if ($urandom_range(0, 9) == 0)
               ad = 32'd0;
         end
         if ($urandom_range(0, 3) == 0)
            bd = ad;
         else if ($urandom_range(0, 7) == 0)
            bd = 32'd1;
         if (op == OP_CMP && $urandom_range(0, 3) == 0) begin
            bn = an;
            bd = ad;
         end
         if (op == OP_DIV && $urandom_range(0, 15) == 0)
            bn = 32'd0;
      end else begin
         an = pick_word();
         ad = pick_word();
         bn = pick_word();
         bd = pick_word();
      end
      add_request(op, an, ad, bn, bd);
   endfunction

   function automatic int unsigned idle_length(int unsigned count);
      int unsigned r;
      if ((count / 150) % 3 == 2)
         return 0;
      r = $urandom_range(0, 19);
      if (r < 12)
         return 0;
      else if (r < 18)
         return $urandom_range(1, 3);
      else
         return $urandom_range(8, 40);
   endfunction

   initial begin
      add_request(OP_NORM, 32'd6, -32'd4, 32'd0, 32'd1);
      add_request(OP_NORM, 32'd0, -32'd5, 32'd0, 32'd1);
      add_request(OP_NORM, 32'd7, 32'd0, 32'd0, 32'd1);
      add_request(OP_NORM, WORD_MIN, 32'hFFFF_FFFF, 32'd0, 32'd1);
      add_request(OP_NORM, 32'd1, WORD_MIN, 32'd0, 32'd1);
      add_request(OP_NORM, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX);
      add_request(OP_NORM, 32'hFFFF_FFFF, WORD_MIN, WORD_MIN, 32'hFFFF_FFFF);
      add_request(OP_ADD, 32'd1, 32'd4, 32'd1, 32'd4);
      add_request(OP_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
      add_request(OP_ADD, WORD_MAX, 32'd1, 32'd1, 32'd1);
      add_request(OP_ADD, WORD_MIN, WORD_MAX, WORD_MIN, 32'd0);
      add_request(OP_SUB, 32'd3, 32'd4, 32'd1, 32'd4);
      add_request(OP_SUB, 32'd1, 32'd2, 32'd3, 32'd1);
      add_request(OP_SUB, WORD_MIN, 32'd1, 32'd1, 32'd1);
      add_request(OP_MUL, 32'd2, 32'd3, 32'd3, 32'd4);
      add_request(OP_MUL, WORD_MIN, 32'd1, WORD_MIN, 32'd1);
      add_request(OP_DIV, 32'd1, 32'd2, 32'd3, 32'd4);
      add_request(OP_DIV, 32'd1, 32'd2, 32'd0, 32'd1);
      add_request(OP_DIV, -32'd5, 32'd7, -32'd2, 32'd3);
      add_request(OP_CMP, 32'd1, 32'd2, 32'd1, 32'd3);
      add_request(OP_CMP, 32'd2, 32'd4, 32'd2, 32'd4);
      add_request(OP_CMP, WORD_MAX, 32'd1, 32'd1, WORD_MAX);
      add_request(OP_CMP, -32'd1, 32'd3, 32'd1, 32'd3);
      add_request(OP_SPARE_6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      add_request(OP_SPARE_7, 32'd0, 32'd0, 32'd0, 32'd0);
      repeat (RANDOM_ITEMS)
         add_random_request();
      total_requests = pending_requests.size();

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      while (accepted_requests != total_requests || expected_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         gap_left <= 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            expected_results.push_back(rational_result(req_if.data));
            accepted_requests <= accepted_requests + 1;
         end
         if (!req_if.valid || req_if.ready) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
               req_if.valid <= 1'b0;
            end else if (pending_requests.size() > 0) begin
               req_if.data <= pending_requests.pop_front();
               req_if.valid <= 1'b1;
               gap_left <= idle_length(accepted_requests);
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      rsp_type e;
      rsp_type a;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         hold_off <= 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            a = rsp_if.data;
            received_results <= received_results + 1;
            if (expected_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("result %0d arrived with no transaction pending: %0d/%0d",
                           received_results, a.res_num, a.res_den);
            end else begin
               e = expected_results.pop_front();
               if (a.res_num !== e.res_num || a.res_den !== e.res_den ||
                   a.less !== e.less || a.greater !== e.greater || a.equal !== e.equal ||
                   a.zero_den !== e.zero_den || a.overflow !== e.overflow) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT) begin
                     $write("result %0d: expected %0d/%0d lt=%b gt=%b eq=%b zd=%b ov=%b,",
                            received_results, e.res_num, e.res_den, e.less, e.greater,
                            e.equal, e.zero_den, e.overflow);
                     $display(" got %0d/%0d lt=%b gt=%b eq=%b zd=%b ov=%b",
                              a.res_num, a.res_den, a.less, a.greater, a.equal,
                              a.zero_den, a.overflow);
                  end
               end
            end
         end
         if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
            if ($urandom_range(0, 7) == 0)
               hold_off <= idle_length(received_results + 75);
         end
      end
   end

   // stall watchdog
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
